@@ design/c2dw_pkg.sv @@
`default_nettype none
package c2dw_pkg;

    // Field and storage widths
    localparam int PIX_W     = 16;
    localparam int VAL_W     = 36;
    localparam int PART_W    = 34;
    localparam int ROW_W     = 13;
    localparam int OCOL_W    = 11;
    localparam int KROW_W    = 48;
    localparam int KREG      = 3;
    localparam int CFG_IDX_W = 4;

    // Default sizing
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int KMAX_DEF      = 3;

    // Mode register bits
    localparam int MODE_FULL_BIT = 0;
    localparam int MODE_FLIP_BIT = 1;

    typedef logic signed [PIX_W-1:0]  pix_t;
    typedef pix_t [KREG-1:0]          col_t;
    typedef logic signed [PART_W-1:0] part_t;
    typedef logic signed [VAL_W-1:0]  val_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KROW0   = 4'd0,
        CFG_KROW1   = 4'd1,
        CFG_KROW2   = 4'd2,
        CFG_KROWS   = 4'd3,
        CFG_KCOLS   = 4'd4,
        CFG_IWIDTH  = 4'd5,
        CFG_IHEIGHT = 4'd6,
        CFG_MODE    = 4'd7
    } cfg_idx_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    // Per-cycle control for one window column cell
    typedef struct packed {
        logic shift;
        logic zero_in;
        logic capture;
    } cell_ctrl_t;

endpackage
`default_nettype wire

@@ design/c2dw_cell.sv @@
`default_nettype none
module c2dw_cell (
    input  wire logic               aclk,
    input  c2dw_pkg::cell_ctrl_t    ctrl,
    input  c2dw_pkg::col_t          col_in,
    input  c2dw_pkg::col_t          coef,
    output c2dw_pkg::col_t          col_out,
    output c2dw_pkg::part_t         part_out
);
    import c2dw_pkg::*;

    col_t                    pix_reg;
    part_t                   part_reg;
    logic signed [31:0]      prod [KREG];
    part_t                   part_next;

    // Column products, summed over the column
    always_comb begin
        part_next = '0;
        for (int i = 0; i < KREG; i++) begin
            prod[i]   = pix_reg[i] * coef[i];
            part_next = part_next + part_t'(prod[i]);
        end
    end

    // Shift pixels from the right neighbor, capture partial sum
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            pix_reg <= ctrl.zero_in ? '0 : col_in;
        end
        if (ctrl.capture) begin
            part_reg <= part_next;
        end
    end

    assign col_out  = pix_reg;
    assign part_out = part_reg;

endmodule
`default_nettype wire

@@ design/c2dw_linebuf.sv @@
`default_nettype none
module c2dw_linebuf #(
    parameter int DEPTH = 1024,
    parameter int DW    = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DW-1:0]            rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DW-1:0]            wr_data
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Registered read; a write to the same column in this cycle is forwarded
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ design/correlate_2d_window.sv @@
// Path: an accepted pixel passes the issue stage, the window cells, the product
// stage and the output register. Throughput: one item per cycle unless the output
// stalls or a full-mode row end is still emitting its trailing padded columns.
// Reset: synchronous active-low aresetn empties the pipeline, zeroes the positions
// and loads the register defaults; line memory is not cleared (rows outside the
// image are masked to zero instead).
`default_nettype none
module correlate_2d_window #(
    parameter int MAX_WIDTH = c2dw_pkg::MAX_WIDTH_DEF,
    parameter int KMAX      = c2dw_pkg::KMAX_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_opcode,
    input  wire logic signed [c2dw_pkg::PIX_W-1:0] s_pixel,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [c2dw_pkg::VAL_W-1:0]      m_value,
    output logic        [c2dw_pkg::ROW_W-1:0]      m_out_row,
    output logic        [c2dw_pkg::OCOL_W-1:0]     m_out_col,
    output logic                                   m_last_of_frame,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic   [c2dw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic   [c2dw_pkg::KROW_W-1:0]     cfg_data
);
    import c2dw_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = AW + 1;
    localparam int KW   = (KMAX < KREG) ? KMAX : KREG;
    localparam int NLB  = (KW > 1) ? KW - 1 : 1;
    localparam int LB_W = NLB * PIX_W;

    // Configuration registers
    logic [KROW_W-1:0] kern_reg [KREG];
    logic [1:0]        krows_reg, kcols_reg, mode_reg;
    logic [10:0]       iwidth_reg;
    logic [11:0]       iheight_reg;

    // Stream position
    logic [ROW_W-1:0]  row_pos_reg, row_pos_next;
    logic [WW-1:0]     col_pos_reg, col_pos_next;

    // Issue stage (item holding its column data)
    logic              s1_valid_reg, s1_main_reg, s1_emit_reg, s1_last_reg;
    logic              s1_rv1_reg, s1_rv2_reg, s1_clear_reg;
    logic [1:0]        s1_ext_reg;
    logic [ROW_W-1:0]  s1_orow_reg;
    logic [OCOL_W-1:0] s1_ocol_reg;
    pix_t              s1_pix_reg;
    logic [AW-1:0]     s1_addr_reg;

    // Window holds a pending result, product stage, output register
    logic              pend_valid_reg, pend_last_reg;
    logic [ROW_W-1:0]  pend_row_reg;
    logic [OCOL_W-1:0] pend_col_reg;
    logic              p_valid_reg, p_last_reg;
    logic [ROW_W-1:0]  p_row_reg;
    logic [OCOL_W-1:0] p_col_reg;
    logic              m_valid_reg, m_last_reg;
    val_t              m_value_reg;
    logic [ROW_W-1:0]  m_row_reg;
    logic [OCOL_W-1:0] m_col_reg;

    // Effective geometry
    logic [1:0]        kr, kc, krm1, kcm1;
    logic [WW-1:0]     w;
    logic [11:0]       h;
    logic              full, flip;
    logic [ROW_W-1:0]  total, h13;

    function automatic logic [1:0] clamp_k(input logic [1:0] k);
        if (k == 2'd0) begin
            return 2'd1;
        end
        if (32'(k) > KW) begin
            return 2'(KW);
        end
        return k;
    endfunction

    always_comb begin
        kr   = clamp_k(krows_reg);
        kc   = clamp_k(kcols_reg);
        krm1 = kr - 2'd1;
        kcm1 = kc - 2'd1;
        if (iwidth_reg == 11'd0) begin
            w = WW'(1);
        end else if (32'(iwidth_reg) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(iwidth_reg);
        end
        h     = (iheight_reg == 12'd0) ? 12'd1 : iheight_reg;
        h13   = ROW_W'(h);
        full  = mode_reg[MODE_FULL_BIT];
        flip  = mode_reg[MODE_FLIP_BIT];
        total = full ? h13 + ROW_W'(krm1) : h13;
    end

    // Coefficient at each window place; unused places are zero
    col_t coef [KREG];
    always_comb begin
        int a, b, ka, kb;
        for (int j = 0; j < KREG; j++) begin
            for (int i = 0; i < KREG; i++) begin
                a = i - (KREG - int'(kr));
                b = j - (KREG - int'(kc));
                ka = flip ? int'(kr) - 1 - a : a;
                kb = flip ? int'(kc) - 1 - b : b;
                coef[j][i] = '0;
                if (a >= 0 && b >= 0) begin
                    coef[j][i] = kern_reg[2'(ka)][16*kb +: 16];
                end
            end
        end
    end

    // Geometry and mode writes restart the frame
    logic cfg_restart;
    always_comb begin
        case (cfg_idx_t'(cfg_index))
            CFG_KROWS, CFG_KCOLS, CFG_IWIDTH, CFG_IHEIGHT, CFG_MODE: cfg_restart = cfg_valid;
            default: cfg_restart = 1'b0;
        endcase
    end

    // Handshake chain
    logic o_free, p_free, p_take, win_free, ev, ev_final, ev_emit, ev_last, s_acc;
    assign o_free   = !m_valid_reg || m_ready;
    assign p_free   = !p_valid_reg || o_free;
    assign p_take   = pend_valid_reg && p_free;
    assign win_free = !pend_valid_reg || p_take;
    assign ev       = s1_valid_reg && win_free;
    assign ev_final = s1_main_reg ? (s1_ext_reg == 2'd0) : (s1_ext_reg == 2'd1);
    assign ev_emit  = s1_main_reg ? s1_emit_reg : 1'b1;
    assign ev_last  = s1_last_reg && ev_final;
    assign s_ready  = !s1_valid_reg || (ev && ev_final);
    assign s_acc    = s_valid && s_ready;

    // Item classification at the input
    logic              r_in_img, act, c_end, v_emit, last_end;
    logic [ROW_W-1:0]  in_orow;
    logic [OCOL_W-1:0] in_ocol;
    logic [1:0]        in_ext;
    pix_t              in_pix;
    always_comb begin
        r_in_img = row_pos_reg < h13;
        act      = (s_opcode == OP_PIXEL) ? r_in_img : (full && !r_in_img);
        c_end    = col_pos_reg == (w - WW'(1));
        v_emit   = (row_pos_reg >= ROW_W'(krm1)) && (col_pos_reg >= WW'(kcm1));
        if (full) begin
            last_end = (row_pos_reg == h13 + ROW_W'(kr) - ROW_W'(2)) && c_end;
            in_orow  = row_pos_reg;
            in_ocol  = OCOL_W'(col_pos_reg);
            in_ext   = c_end ? kcm1 : 2'd0;
        end else begin
            last_end = (row_pos_reg == h13 - ROW_W'(1)) && c_end;
            in_orow  = row_pos_reg - ROW_W'(krm1);
            in_ocol  = OCOL_W'(col_pos_reg - WW'(kcm1));
            in_ext   = 2'd0;
        end
        in_pix = (s_opcode == OP_PIXEL) ? s_pixel : '0;
        col_pos_next = c_end ? '0 : col_pos_reg + WW'(1);
        row_pos_next = row_pos_reg;
        if (c_end) begin
            row_pos_next = (row_pos_reg + ROW_W'(1) >= total) ? '0
                                                              : row_pos_reg + ROW_W'(1);
        end
    end

    // Line memory of the rows above
    logic [LB_W-1:0] rd_data, wr_data;
    pix_t            rd_ext [KREG-1];
    logic            wr_en;

    always_comb begin
        for (int k = 0; k < KREG - 1; k++) begin
            rd_ext[k] = '0;
        end
        for (int k = 0; k < NLB; k++) begin
            rd_ext[k] = rd_data[k*PIX_W +: PIX_W];
        end
        wr_data[PIX_W-1:0] = s1_pix_reg;
        for (int k = 1; k < NLB; k++) begin
            wr_data[k*PIX_W +: PIX_W] = rd_ext[k-1];
        end
    end
    assign wr_en = ev && s1_main_reg;

    c2dw_linebuf #(
        .DEPTH (MAX_WIDTH),
        .DW    (LB_W)
    ) u_linebuf (
        .aclk    (aclk),
        .rd_en   (s_acc),
        .rd_addr (col_pos_reg[AW-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data)
    );

    // New column entering the window: bottom is the current row
    col_t col_new;
    always_comb begin
        col_new    = '0;
        if (s1_main_reg) begin
            col_new[KREG-1] = s1_pix_reg;
            if (KW >= 2 && s1_rv1_reg) begin
                col_new[KREG-2] = rd_ext[0];
            end
            if (KW >= 3 && s1_rv2_reg) begin
                col_new[KREG-3] = rd_ext[KREG-2];
            end
        end
    end

    // Chain of window column cells, rightmost takes the new column
    col_t       cell_col [KREG];
    part_t      cell_part [KREG];
    cell_ctrl_t cell_ctrl [KREG];

    for (genvar j = 0; j < KREG; j++) begin : g_cell
        always_comb begin
            cell_ctrl[j].shift   = ev;
            cell_ctrl[j].capture = p_take;
            cell_ctrl[j].zero_in = (j < KREG - 1) && s1_main_reg && s1_clear_reg;
        end
        c2dw_cell u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl[j]),
            .col_in   ((j == KREG - 1) ? col_new : cell_col[(j + 1) % KREG]),
            .coef     (coef[j]),
            .col_out  (cell_col[j]),
            .part_out (cell_part[j])
        );
    end

    val_t sum_next;
    always_comb begin
        sum_next = '0;
        for (int j = 0; j < KREG; j++) begin
            sum_next = sum_next + val_t'(cell_part[j]);
        end
    end

    // Control and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < KREG; k++) begin
                kern_reg[k] <= '0;
            end
            krows_reg      <= 2'd3;
            kcols_reg      <= 2'd3;
            iwidth_reg     <= 11'd1024;
            iheight_reg    <= 12'd1;
            mode_reg       <= 2'd0;
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            p_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // accepted active item loads the issue stage, else it drains one window shift per event
            if (s_acc && act) begin
                s1_valid_reg <= 1'b1;
                s1_main_reg  <= 1'b1;
                s1_ext_reg   <= in_ext;
                s1_emit_reg  <= full || v_emit;
                s1_last_reg  <= last_end;
                s1_orow_reg  <= in_orow;
                s1_ocol_reg  <= in_ocol;
                s1_pix_reg   <= in_pix;
                s1_rv1_reg   <= (row_pos_reg >= ROW_W'(1)) && (row_pos_reg <= h13);
                s1_rv2_reg   <= (row_pos_reg >= ROW_W'(2))
                                && (row_pos_reg <= h13 + ROW_W'(1));
                s1_clear_reg <= col_pos_reg == '0;
                s1_addr_reg  <= col_pos_reg[AW-1:0];
            end else if (ev) begin
                if (ev_final) begin
                    s1_valid_reg <= 1'b0;
                end
                s1_main_reg <= 1'b0;
                if (s1_main_reg) begin
                    s1_ocol_reg <= OCOL_W'(w);
                end else begin
                    s1_ext_reg  <= s1_ext_reg - 2'd1;
                    s1_ocol_reg <= s1_ocol_reg + OCOL_W'(1);
                end
            end

            // stream position
            if (cfg_restart) begin
                row_pos_reg <= '0;
                col_pos_reg <= '0;
            end else if (s_acc && act) begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
            end

            // window pending result
            if (ev) begin
                pend_valid_reg <= ev_emit;
                pend_row_reg   <= s1_orow_reg;
                pend_col_reg   <= s1_ocol_reg;
                pend_last_reg  <= ev_last;
            end else if (p_take) begin
                pend_valid_reg <= 1'b0;
            end

            // product stage
            if (p_take) begin
                p_valid_reg <= 1'b1;
                p_row_reg   <= pend_row_reg;
                p_col_reg   <= pend_col_reg;
                p_last_reg  <= pend_last_reg;
            end else if (o_free) begin
                p_valid_reg <= 1'b0;
            end

            // output register
            if (o_free) begin
                m_valid_reg <= p_valid_reg;
                m_value_reg <= sum_next;
                m_row_reg   <= p_row_reg;
                m_col_reg   <= p_col_reg;
                m_last_reg  <= p_last_reg;
            end

            // configuration registers
            if (cfg_valid) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_KROW0:   kern_reg[0] <= cfg_data;
                    CFG_KROW1:   kern_reg[1] <= cfg_data;
                    CFG_KROW2:   kern_reg[2] <= cfg_data;
                    CFG_KROWS:   krows_reg   <= cfg_data[1:0];
                    CFG_KCOLS:   kcols_reg   <= cfg_data[1:0];
                    CFG_IWIDTH:  iwidth_reg  <= cfg_data[10:0];
                    CFG_IHEIGHT: iheight_reg <= cfg_data[11:0];
                    CFG_MODE:    mode_reg    <= cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_value         = m_value_reg;
    assign m_out_row       = m_row_reg;
    assign m_out_col       = m_col_reg;
    assign m_last_of_frame = m_last_reg;

endmodule
`default_nettype wire

@@ design/c2dw_checker.sv @@
`default_nettype none
module c2dw_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic                              s_opcode,
    input wire logic signed [c2dw_pkg::PIX_W-1:0] s_pixel,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic signed [c2dw_pkg::VAL_W-1:0] m_value,
    input wire logic        [c2dw_pkg::ROW_W-1:0] m_out_row,
    input wire logic        [c2dw_pkg::OCOL_W-1:0] m_out_col,
    input wire logic                              m_last_of_frame,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready
);
    // Stalled result holds its item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_out_row)
                                && $stable(m_out_col) && $stable(m_last_of_frame))
        else $error("result changed while stalled");

    // Waiting input item stays put
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_opcode) && $stable(s_pixel))
        else $error("input item changed while waiting");

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Empty pipeline takes input at once
    a_rst_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    // Register writes never stall
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind correlate_2d_window c2dw_checker u_c2dw_checker (.*);
`default_nettype wire

@@ dv/tb_correlate_2d_window.sv @@
`timescale 1ns / 1ps
module tb_correlate_2d_window;
    import c2dw_pkg::*;

    localparam int MAXW        = MAX_WIDTH_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int FRAME_CAP   = 80;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;

    typedef struct packed {
        val_t              value;
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic              last;
    } conv_out_t;

    // one directed step: a register write or an item, optionally with a known result
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [KROW_W-1:0]    data;
        op_t                  op;
        pix_t                 px;
        bit                   known;
        conv_out_t            res;
    } step_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_opcode;
    pix_t                 s_pixel;
    logic                 m_valid;
    logic                 m_ready;
    val_t                 m_value;
    logic [ROW_W-1:0]     m_out_row;
    logic [OCOL_W-1:0]    m_out_col;
    logic                 m_last_of_frame;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [KROW_W-1:0]    cfg_data;

    correlate_2d_window u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode), .s_pixel(s_pixel),
        .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value),
        .m_out_row(m_out_row), .m_out_col(m_out_col), .m_last_of_frame(m_last_of_frame),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // shadow of the block: registers, line rows and stream position
    logic [KROW_W-1:0] kern_row [KREG];
    logic [1:0]        k_rows, k_cols, mode_reg;
    logic [10:0]       img_w;
    logic [11:0]       img_h;
    pix_t              line_mem [3][MAXW];
    int                pos_row, pos_col;

    conv_out_t expected_q[$];
    int        err_count;
    int        idle_cycles;
    int        items_sent;
    bit        cur_known;
    conv_out_t cur_res;

    function automatic int eff_k(logic [1:0] k);
        return (k == 0) ? 1 : int'(k);
    endfunction

    function automatic int eff_w();
        if (img_w == 0) return 1;
        return (img_w > MAXW) ? MAXW : int'(img_w);
    endfunction

    function automatic int eff_h();
        return (img_h == 0) ? 1 : int'(img_h);
    endfunction

    function automatic val_t window_sum(int top, int left);
        int     kr, kc, w, h, ka, kb;
        longint acc;
        pix_t   p, coef;
        kr  = eff_k(k_rows);
        kc  = eff_k(k_cols);
        w   = eff_w();
        h   = eff_h();
        acc = 0;
        for (int a = 0; a < kr; a++) begin
            for (int b = 0; b < kc; b++) begin
                if (top + a < 0 || left + b < 0 || top + a >= h || left + b >= w)
                    p = '0;
                else
                    p = line_mem[(top + a) % 3][left + b];
                ka   = mode_reg[MODE_FLIP_BIT] ? kr - 1 - a : a;
                kb   = mode_reg[MODE_FLIP_BIT] ? kc - 1 - b : b;
                coef = kern_row[ka][16*kb +: 16];
                acc += longint'(p) * longint'(coef);
            end
        end
        return val_t'(acc);
    endfunction

    // expected outputs of one accepted item, appended to expected_q
    task automatic predict_item(op_t op, pix_t px);
        int        kr, kc, w, h, total, jend;
        bit        full;
        conv_out_t nxt;
        kr    = eff_k(k_rows);
        kc    = eff_k(k_cols);
        w     = eff_w();
        h     = eff_h();
        full  = mode_reg[MODE_FULL_BIT];
        total = full ? h + kr - 1 : h;
        if (op == OP_PIXEL) begin
            if (pos_row >= h) return;
            line_mem[pos_row % 3][pos_col] = px;
        end else if (!full || pos_row < h) begin
            return;
        end
        if (full) begin
            jend = (pos_col == w - 1) ? w + kc - 2 : pos_col;
            for (int j = pos_col; j <= jend; j++) begin
                nxt = '{window_sum(pos_row - kr + 1, j - kc + 1),
                    ROW_W'(pos_row), OCOL_W'(j), pos_row == h + kr - 2 && j == w + kc - 2};
                expected_q = {expected_q, nxt};
            end
        end else if (pos_row >= kr - 1 && pos_col >= kc - 1) begin
            nxt = '{window_sum(pos_row - kr + 1, pos_col - kc + 1),
                ROW_W'(pos_row - kr + 1), OCOL_W'(pos_col - kc + 1),
                pos_row == h - 1 && pos_col == w - 1};
            expected_q = {expected_q, nxt};
        end
        pos_col++;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= total) pos_row = 0;
        end
    endtask

    task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [KROW_W-1:0] data);
        case (idx)
            CFG_KROW0, CFG_KROW1, CFG_KROW2: begin
                kern_row[idx] = data;
                return;
            end
            CFG_KROWS:   k_rows   = data[1:0];
            CFG_KCOLS:   k_cols   = data[1:0];
            CFG_IWIDTH:  img_w    = data[10:0];
            CFG_IHEIGHT: img_h    = data[11:0];
            CFG_MODE:    mode_reg = data[1:0];
            default: return;
        endcase
        pos_row = 0;
        pos_col = 0;
    endtask

    task automatic report(string what, longint got, longint want);
        err_count++;
        $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
    endtask

    // handshakes, prediction and checking at the rising edge
    always @(posedge aclk) begin
        conv_out_t exp_res;
        bit        busy;
        busy = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                apply_reg(cfg_index, cfg_data);
                busy = 1'b1;
            end
            if (s_valid && s_ready) begin
                predict_item(op_t'(s_opcode), s_pixel);
                if (cur_known) begin
                    expected_q[expected_q.size() - 1] = cur_res;
                end
                busy = 1'b1;
            end
            if (m_valid && m_ready) begin
                busy = 1'b1;
                if (expected_q.size() == 0) begin
                    report("unexpected result, row", m_out_row, -1);
                end else begin
                    exp_res = expected_q.pop_front();
                    if (m_value !== exp_res.value) report("value", m_value, exp_res.value);
                    if (m_out_row !== exp_res.row) report("out_row", m_out_row, exp_res.row);
                    if (m_out_col !== exp_res.col) report("out_col", m_out_col, exp_res.col);
                    if (m_last_of_frame !== exp_res.last)
                        report("last_of_frame", m_last_of_frame, exp_res.last);
                end
            end
            idle_cycles <= busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // receiver: stall pattern redrawn at random from four styles as rx_count wraps
    int rx_style, rx_count;
    always @(negedge aclk) begin
        if (rx_count % 64 == 0) rx_style <= $urandom_range(0, 3);
        rx_count <= rx_count + 1;
        case (rx_style)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= (rx_count % 32) >= 20;
        endcase
    end

    int burst_left;

    task automatic send_item(op_t op, pix_t px, bit known = 0, conv_out_t res = '0);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_pixel   <= px;
        cur_known <= known;
        cur_res   <= res;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        // a trailing item with no output may still be in flight
        repeat (10) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [KROW_W-1:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic pix_t rand_pix();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return pix_t'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom());
        endcase
    endfunction

    // one frame of well-formed traffic with some stray items mixed in;
    // wide frames are cut short, the next register write restarts them
    task automatic send_frame();
        int w, h, kr, n_pix, n_drain, n_total;
        w       = eff_w();
        h       = eff_h();
        kr      = eff_k(k_rows);
        n_pix   = w * h;
        n_drain = mode_reg[MODE_FULL_BIT] ? (kr - 1) * w : 0;
        n_total = (n_pix + n_drain > FRAME_CAP) ? FRAME_CAP : n_pix + n_drain;
        for (int i = 0; i < n_total; i++) begin
            if ($urandom_range(0, 11) == 0)
                send_item(op_t'($urandom_range(0, 1)), rand_pix());
            send_item(i < n_pix ? OP_PIXEL : OP_DRAIN, rand_pix());
        end
    endtask

    step_t directed [] = '{
        '{1, CFG_KROWS,   48'd1, OP_PIXEL, 0, 0, '0},
        '{1, CFG_KCOLS,   48'd1, OP_PIXEL, 0, 0, '0},
        '{1, CFG_IWIDTH,  48'd2, OP_PIXEL, 0, 0, '0},
        '{1, CFG_IHEIGHT, 48'd1, OP_PIXEL, 0, 0, '0},
        '{1, CFG_MODE,    48'd0, OP_PIXEL, 0, 0, '0},
        '{1, CFG_KROW0,   48'h7FFF, OP_PIXEL, 0, 0, '0},
        '{0, 0, 0, OP_PIXEL, 16'sh8000, 1, '{-36'sd1073709056, 13'd0, 11'd0, 1'b0}},
        '{0, 0, 0, OP_PIXEL, 16'sh7FFF, 1, '{36'sd1073676289,  13'd0, 11'd1, 1'b1}},
        // coefficient write takes effect without restarting the frame
        '{1, CFG_KROW0,   48'h8000, OP_PIXEL, 0, 0, '0},
        '{0, 0, 0, OP_PIXEL, 16'sh8000, 1, '{36'sd1073741824,  13'd0, 11'd0, 1'b0}},
        '{0, 0, 0, OP_PIXEL, 16'sh7FFF, 1, '{-36'sd1073709056, 13'd0, 11'd1, 1'b1}},
        // drain in valid mode is ignored
        '{0, 0, 0, OP_DRAIN, 16'sh1234, 0, '0},
        '{1, CFG_UNUSED,  48'hFFFF_FFFF_FFFF, OP_PIXEL, 0, 0, '0},
        '{1, CFG_KROW0,   48'h8000_7FFF_0100, OP_PIXEL, 0, 0, '0},
        '{1, CFG_KROW1,   48'hFF00_0080_8000, OP_PIXEL, 0, 0, '0},
        '{1, CFG_KROW2,   48'h7FFF_FFFF_0001, OP_PIXEL, 0, 0, '0},
        '{1, CFG_KROWS,   48'd3, OP_PIXEL, 0, 0, '0},
        '{1, CFG_KCOLS,   48'd3, OP_PIXEL, 0, 0, '0},
        '{1, CFG_IWIDTH,  48'd3, OP_PIXEL, 0, 0, '0},
        '{1, CFG_IHEIGHT, 48'd2, OP_PIXEL, 0, 0, '0},
        '{1, CFG_MODE,    48'd1, OP_PIXEL, 0, 0, '0},
        // drain while pixels are still due is ignored
        '{0, 0, 0, OP_DRAIN, 16'sh0000, 0, '0},
        '{0, 0, 0, OP_PIXEL, 16'sh7FFF, 0, '0},
        '{0, 0, 0, OP_PIXEL, 16'sh8000, 0, '0},
        '{0, 0, 0, OP_PIXEL, 16'sh0100, 0, '0},
        '{0, 0, 0, OP_PIXEL, 16'shFFFF, 0, '0},
        '{0, 0, 0, OP_PIXEL, 16'sh5555, 0, '0},
        '{0, 0, 0, OP_PIXEL, 16'shAAAA, 0, '0},
        // pixel during the padding rows is ignored
        '{0, 0, 0, OP_PIXEL, 16'sh7777, 0, '0},
        '{0, 0, 0, OP_DRAIN, 16'sh0000, 0, '0},
        '{0, 0, 0, OP_DRAIN, 16'sh0000, 0, '0},
        '{0, 0, 0, OP_DRAIN, 16'sh0000, 0, '0},
        '{0, 0, 0, OP_DRAIN, 16'sh0000, 0, '0},
        '{0, 0, 0, OP_DRAIN, 16'sh0000, 0, '0},
        '{0, 0, 0, OP_DRAIN, 16'sh0000, 0, '0}
    };

    initial begin
        int phase;
        logic [CFG_IDX_W-1:0] order [8];
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_opcode   = 1'b0;
        s_pixel    = '0;
        m_ready    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        cur_known  = 0;
        cur_res    = '0;
        err_count  = 0;
        idle_cycles = 0;
        items_sent = 0;
        burst_left = 0;
        rx_style   = 0;
        rx_count   = 0;
        foreach (kern_row[i]) kern_row[i] = '0;
        foreach (line_mem[i, j]) line_mem[i][j] = '0;
        k_rows   = 2'd3;
        k_cols   = 2'd3;
        img_w    = 11'd1024;
        img_h    = 12'd1;
        mode_reg = 2'd0;
        pos_row  = 0;
        pos_col  = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) begin
            if (directed[i].is_cfg)
                write_reg(directed[i].idx, directed[i].data);
            else
                send_item(directed[i].op, directed[i].px, directed[i].known, directed[i].res);
        end

        // random phases: new setting, then one or two frames
        phase = 0;
        while (items_sent < 300) begin
            for (int i = 0; i < 8; i++) order[i] = CFG_IDX_W'(i);
            order.shuffle();
            foreach (order[i]) begin
                case (order[i])
                    CFG_KROW0, CFG_KROW1, CFG_KROW2:
                        if ($urandom_range(0, 1))
                            write_reg(order[i], {rand_coef(), rand_coef(), rand_coef()});
                    CFG_KROWS, CFG_KCOLS:
                        write_reg(order[i], KROW_W'($urandom_range(0, 3)));
                    CFG_IWIDTH: begin
                        case ($urandom_range(0, 19))
                            0: write_reg(CFG_IWIDTH, 48'd1024);
                            1: write_reg(CFG_IWIDTH, 48'd2047);
                            2: write_reg(CFG_IWIDTH, 48'd0);
                            default: write_reg(CFG_IWIDTH, KROW_W'($urandom_range(1, 6)));
                        endcase
                    end
                    CFG_IHEIGHT:
                        write_reg(CFG_IHEIGHT, KROW_W'((img_w == 0 || img_w > 6)
                                             ? $urandom_range(0, 1)
                                             : ($urandom_range(0, 9) == 0 ? 0
                                             : $urandom_range(1, 5))));
                    CFG_MODE: write_reg(CFG_MODE, KROW_W'($urandom_range(0, 3)));
                    default: ;
                endcase
            end
            if ($urandom_range(0, 15) == 0)
                write_reg(CFG_UNUSED, KROW_W'({$urandom(), $urandom()}));
            send_frame();
            if (phase % 5 == 2) wait_drained();
            if ($urandom_range(0, 2) == 0 && eff_w() <= 6) send_frame();
            phase++;
        end

        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (err_count == 0 && expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
